// ----- design/illm_pkg.sv -----
`timescale 1ns / 1ps

package illm_pkg;

  // Pool geometry; node indices are 10 bits wide on both channels
  localparam int IDX_W      = 10;
  localparam int POOL_SIZE  = 1 << IDX_W;
  localparam int ROOT_INDEX = 0;
  localparam int CNT_W      = 10;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam idx_t ROOT_SLOT = idx_t'(ROOT_INDEX % POOL_SIZE);

  typedef enum logic [2:0] {
    ACT_ADD_HEAD  = 3'd0,
    ACT_ADD_TAIL  = 3'd1,
    ACT_MOVE_HEAD = 3'd2,
    ACT_MOVE_TAIL = 3'd3,
    ACT_REMOVE    = 3'd4
  } action_t;

  // One pending link write
  typedef struct packed {
    logic en;
    idx_t addr;
    idx_t data;
  } link_wr_t;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_DEC   = 7'b0000100,
    ST_W0    = 7'b0001000,
    ST_W1    = 7'b0010000,
    ST_W2    = 7'b0100000,
    ST_HOLD  = 7'b1000000
  } state_t;

endpackage

// ----- design/illm_ram.sv -----
`timescale 1ns / 1ps

module illm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/indexed_lru_list_manager.sv -----
`timescale 1ns / 1ps
// Index-linked LRU list manager.
// A circular doubly linked list over a 1024-entry pool; links are entry
// indices held in two 1-read/1-write memories (next and prev), and the root
// sentinel's own links (head and tail) live in registers.
// Input channel in_*: one beat per request (action, node_index). Output
// channel out_*: one beat per request (applied, count, head, tail).
// Steps: the named entry is read at the accepting edge, then a decode state
// and three write states (each memory takes at most three link writes per
// request, one per cycle on its single write port); the result then goes
// into the output register. A new request is taken only once the last one
// is through its write states and its result is in the output register;
// in_tready is high in the idle state.
// Reset: after rst_n goes high the block sweeps both memories, writing each
// entry's own index, one entry a cycle, with in_tready low.
// Stall: the result sits in an output register; the block takes and works
// the next request meanwhile and holds its completed result until the
// output register frees up.

module indexed_lru_list_manager
  import illm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] action, [12:3] node_index, [15:13] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [0] applied, [10:1] node_count,
                                  // [20:11] head_index, [30:21] tail_index, [31] zero
);

  state_t   state_r, state_nxt;
  idx_t     clr_r;
  logic [2:0] act_r;
  idx_t     idx_r;
  idx_t     head_r, tail_r;
  cnt_t     count_r;
  logic     applied_r;
  link_wr_t nwr_r [3];
  link_wr_t pwr_r [3];
  logic     out_valid_r;
  logic [31:0] out_data_r;

  // Memory ports
  logic n_we, p_we;
  idx_t n_waddr, n_wdata, p_waddr, p_wdata;
  idx_t rd_addr, rd_next, rd_prev;

  illm_ram #(.WIDTH(IDX_W), .DEPTH(POOL_SIZE)) u_next_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (rd_addr),
    .rdata (rd_next)
  );

  illm_ram #(.WIDTH(IDX_W), .DEPTH(POOL_SIZE)) u_prev_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (rd_addr),
    .rdata (rd_prev)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Read the named entry straight off the input beat
  assign rd_addr = in_tdata[12:3];

  // Write port select: clearing sweep or the queued link writes
  always_comb begin
    n_we = 1'b0; n_waddr = clr_r; n_wdata = clr_r;
    p_we = 1'b0; p_waddr = clr_r; p_wdata = clr_r;
    unique case (state_r)
      ST_CLEAR: begin
        n_we = 1'b1;
        p_we = 1'b1;
      end
      ST_W0: begin
        n_we = nwr_r[0].en; n_waddr = nwr_r[0].addr; n_wdata = nwr_r[0].data;
        p_we = pwr_r[0].en; p_waddr = pwr_r[0].addr; p_wdata = pwr_r[0].data;
      end
      ST_W1: begin
        n_we = nwr_r[1].en; n_waddr = nwr_r[1].addr; n_wdata = nwr_r[1].data;
        p_we = pwr_r[1].en; p_waddr = pwr_r[1].addr; p_wdata = pwr_r[1].data;
      end
      ST_W2: begin
        n_we = nwr_r[2].en; n_waddr = nwr_r[2].addr; n_wdata = nwr_r[2].data;
        p_we = pwr_r[2].en; p_waddr = pwr_r[2].addr; p_wdata = pwr_r[2].data;
      end
      default: begin
      end
    endcase
  end

  // Decode: decide detach/attach from the entry's links and the root links
  logic req_ok, linked, do_detach, do_attach, at_head;
  idx_t nx, pv, h1, t1, p_ins, x_ins, h2, t2;
  cnt_t count_dec;

  always_comb begin
    nx = rd_next;
    pv = rd_prev;
    req_ok = (idx_r != ROOT_SLOT) && (act_r <= ACT_REMOVE);
    linked = (nx != idx_r);
    do_detach = 1'b0;
    do_attach = 1'b0;
    at_head   = 1'b0;
    case (act_r)
      ACT_ADD_HEAD: begin
        do_attach = !linked;
        at_head   = 1'b1;
      end
      ACT_ADD_TAIL: begin
        do_attach = !linked;
      end
      ACT_MOVE_HEAD: begin
        do_detach = linked && (pv != ROOT_SLOT);
        do_attach = !linked || (pv != ROOT_SLOT);
        at_head   = 1'b1;
      end
      ACT_MOVE_TAIL: begin
        do_detach = linked && (nx != ROOT_SLOT);
        do_attach = !linked || (nx != ROOT_SLOT);
      end
      ACT_REMOVE: begin
        do_detach = linked;
      end
      default: begin
      end
    endcase
    do_detach = do_detach && req_ok;
    do_attach = do_attach && req_ok;

    // Root links after the unlink step
    h1 = (do_detach && pv == ROOT_SLOT) ? nx : head_r;
    t1 = (do_detach && nx == ROOT_SLOT) ? pv : tail_r;
    // Insert between p_ins and x_ins
    p_ins = at_head ? ROOT_SLOT : t1;
    x_ins = at_head ? h1 : ROOT_SLOT;
    h2 = (do_attach && p_ins == ROOT_SLOT) ? idx_r : h1;
    t2 = (do_attach && x_ins == ROOT_SLOT) ? idx_r : t1;

    count_dec = count_r;
    if (do_detach && !do_attach) begin
      count_dec = count_r - cnt_t'(1);
    end else if (do_attach && !do_detach) begin
      count_dec = count_r + cnt_t'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == idx_t'(POOL_SIZE - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_DEC;
      ST_DEC:   state_nxt = ST_W0;
      ST_W0:    state_nxt = ST_W1;
      ST_W1:    state_nxt = ST_W2;
      ST_W2:    state_nxt = (!out_valid_r || out_tready) ? ST_IDLE : ST_HOLD;
      ST_HOLD:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  logic load_out;
  assign load_out = (state_r == ST_W2 || state_r == ST_HOLD) && (!out_valid_r || out_tready);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      head_r      <= ROOT_SLOT;
      tail_r      <= ROOT_SLOT;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + idx_t'(1);
      end
      if (state_r == ST_DEC) begin
        head_r  <= h2;
        tail_r  <= t2;
        count_r <= count_dec;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: request, queued writes, result
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      act_r <= in_tdata[2:0];
      idx_r <= in_tdata[12:3];
    end
    if (state_r == ST_DEC) begin
      applied_r <= do_detach || do_attach;
      // Unlink: next[pv] = nx, prev[nx] = pv
      nwr_r[0] <= '{en: do_detach, addr: pv, data: nx};
      pwr_r[0] <= '{en: do_detach, addr: nx, data: pv};
      if (do_attach) begin
        nwr_r[1] <= '{en: 1'b1, addr: idx_r, data: x_ins};
        pwr_r[1] <= '{en: 1'b1, addr: x_ins, data: idx_r};
      end else begin
        // Plain remove: make the entry self-linked
        nwr_r[1] <= '{en: do_detach, addr: idx_r, data: idx_r};
        pwr_r[1] <= '{en: do_detach, addr: idx_r, data: idx_r};
      end
      nwr_r[2] <= '{en: do_attach, addr: p_ins, data: idx_r};
      pwr_r[2] <= '{en: do_attach, addr: idx_r, data: p_ins};
    end
    if (load_out) begin
      out_data_r <= {1'b0, tail_r, head_r, count_r, applied_r};
    end
  end

endmodule

// ----- tb/indexed_lru_list_manager_tb.sv -----
`timescale 1ns / 1ps

module indexed_lru_list_manager_tb;
  import illm_pkg::*;

  // Action codes outside the defined set; the block must ignore them
  localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

  localparam int PHASE_BEATS    = 450;
  // Covers the clearing sweep after reset plus a long receiver stall
  localparam int WATCHDOG_LIMIT = 5000;
  // Drain margin at the end
  localparam int DRAIN_CYCLES   = 20;

  // Status beat as it sits in out_tdata, lowest field last
  typedef struct packed {
    logic pad;
    idx_t tail;
    idx_t head;
    cnt_t count;
    logic applied;
  } list_status_t;

  // Shadow copy of the linked list; predicts the status beat of each request
  class lru_list_tracker;
    idx_t         next_link[POOL_SIZE];
    idx_t         prev_link[POOL_SIZE];
    cnt_t         linked_count;
    list_status_t pending_status[$];
    int           errors;

    function new();
      for (int i = 0; i < POOL_SIZE; i++) begin
        next_link[i] = idx_t'(i);
        prev_link[i] = idx_t'(i);
      end
      linked_count = '0;
      errors       = 0;
    endfunction

    function int pending();
      return pending_status.size();
    endfunction

    // Cut entry n out of the ring and make it point to itself
    function void unlink(idx_t n);
      idx_t p;
      idx_t x;
      p = prev_link[n];
      x = next_link[n];
      next_link[p] = x;
      prev_link[x] = p;
      next_link[n] = n;
      prev_link[n] = n;
      linked_count = linked_count - cnt_t'(1);
    endfunction

    // Splice free entry n in right after entry p
    function void link_after(idx_t n, idx_t p);
      idx_t x;
      x = next_link[p];
      prev_link[x] = n;
      next_link[n] = x;
      prev_link[n] = p;
      next_link[p] = n;
      linked_count = linked_count + cnt_t'(1);
    endfunction

    // Apply one accepted request and queue the status it must answer with.
    // The pool spans the whole 10-bit index, so only the root is out of bounds.
    function void note_request(logic [2:0] act, idx_t n);
      list_status_t st;
      logic         is_linked;
      logic         changed;
      changed   = 1'b0;
      is_linked = (next_link[n] != n);
      if (n != ROOT_SLOT) begin
        case (act)
          ACT_ADD_HEAD: begin
            if (!is_linked) begin
              link_after(n, ROOT_SLOT);
              changed = 1'b1;
            end
          end
          ACT_ADD_TAIL: begin
            if (!is_linked) begin
              link_after(n, prev_link[ROOT_SLOT]);
              changed = 1'b1;
            end
          end
          ACT_MOVE_HEAD: begin
            // already at the head: nothing to do
            if (!is_linked || prev_link[n] != ROOT_SLOT) begin
              if (is_linked) unlink(n);
              link_after(n, ROOT_SLOT);
              changed = 1'b1;
            end
          end
          ACT_MOVE_TAIL: begin
            if (!is_linked || next_link[n] != ROOT_SLOT) begin
              if (is_linked) unlink(n);
              link_after(n, prev_link[ROOT_SLOT]);
              changed = 1'b1;
            end
          end
          ACT_REMOVE: begin
            if (is_linked) begin
              unlink(n);
              changed = 1'b1;
            end
          end
          default: ;
        endcase
      end
      st.pad     = 1'b0;
      st.applied = changed;
      st.count   = linked_count;
      st.head    = next_link[ROOT_SLOT];
      st.tail    = prev_link[ROOT_SLOT];
      pending_status.push_back(st);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [31:0] data);
      list_status_t want;
      list_status_t got;
      got = data;
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected status beat: expected none, actual 0x%08h", $time, data);
        errors++;
        return;
      end
      want = pending_status.pop_front();
      compare_field("applied", want.applied, got.applied);
      compare_field("node_count", want.count, got.count);
      compare_field("head_index", want.head, got.head);
      compare_field("tail_index", want.tail, got.tail);
      compare_field("pad bit", 0, got.pad);
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;  // [2:0] action, [12:3] node_index, [15:13] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [0] applied, [10:1] node_count,
                                 // [20:11] head_index, [30:21] tail_index, [31] zero

  lru_list_tracker tracker = new();

  int send_idle_pct = 37;
  int recv_idle_pct = 82;
  int quiet_cycles  = 0;

  always #5 clk = ~clk;

  indexed_lru_list_manager i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Receiver: drop tready at random for the current share of cycles
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check each status beat; watchdog counts cycles with no beat on either side
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_result(out_tdata);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d status beats pending", $time,
               tracker.pending());
      $display("indexed_lru_list_manager_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request beat, idling at random first; hold it until taken
  task automatic send_req(input logic [2:0] act, input idx_t n);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, n, act};
    do @(posedge clk); while (!in_tready);
    tracker.note_request(act, n);
  endtask

  // Hold off the sender until every queued status has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Mostly a small set of low and high entries so the ring fills, reorders
  // and empties often; the rest spreads over the pool, the root and junk codes
  task automatic send_random();
    logic [2:0] act;
    idx_t       n;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)      n = idx_t'($urandom_range(1, 12));
    else if (pick < 85) n = idx_t'($urandom_range(POOL_SIZE - 12, POOL_SIZE - 1));
    else if (pick < 96) n = idx_t'($urandom_range(0, POOL_SIZE - 1));
    else                n = ROOT_SLOT;
    if ($urandom_range(0, 99) < 94) act = 3'($urandom_range(ACT_ADD_HEAD, ACT_REMOVE));
    else act = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
    send_req(act, n);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: duplicate adds, stray removes, moves in place, moves of linked
    // and free entries, requests on the root, unused codes, extreme indices
    send_req(ACT_ADD_HEAD, 10'd5);
    send_req(ACT_ADD_TAIL, 10'd1023);
    send_req(ACT_ADD_HEAD, 10'd5);
    send_req(ACT_REMOVE, 10'd9);
    send_req(ACT_MOVE_HEAD, 10'd5);
    send_req(ACT_MOVE_TAIL, 10'd1023);
    send_req(ACT_ADD_TAIL, 10'd512);
    send_req(ACT_MOVE_HEAD, 10'd512);
    send_req(ACT_MOVE_TAIL, 10'd5);
    send_req(ACT_MOVE_HEAD, 10'd7);
    send_req(ACT_MOVE_TAIL, 10'd8);
    send_req(ACT_ADD_HEAD, ROOT_SLOT);
    send_req(ACT_ADD_TAIL, ROOT_SLOT);
    send_req(ACT_MOVE_HEAD, ROOT_SLOT);
    send_req(ACT_MOVE_TAIL, ROOT_SLOT);
    send_req(ACT_REMOVE, ROOT_SLOT);
    for (int a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++) begin
      send_req(3'(a), 10'd3);
    end
    send_req(ACT_ADD_HEAD, 10'd682);
    send_req(ACT_ADD_TAIL, 10'd341);
    send_req(ACT_REMOVE, 10'd1023);
    send_req(ACT_REMOVE, 10'd5);
    send_req(ACT_REMOVE, 10'd5);
    drain();

    // Random: slow sender / slow receiver, then swapped, then full rate
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 82 : 0;
      recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 37 : 0;
      for (int i = 0; i < PHASE_BEATS; i++) begin
        send_random();
        // occasionally let the pipe run dry mid-phase
        if ($urandom_range(0, 199) == 0) drain();
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("indexed_lru_list_manager_tb: PASS");
    end else begin
      $display("indexed_lru_list_manager_tb: FAIL");
    end
    $finish;
  end

endmodule
